// ===== rtl/gdqi_pkg.sv =====
// shared types and constants of the genotype dosage qc and impute block
package gdqi_pkg;

  localparam int unsigned DOSE_W = 16;
  localparam int unsigned Q_W    = 17;
  localparam int unsigned CNT_OUT_W = 13;
  localparam int unsigned CFG_W  = 17;

  localparam logic [DOSE_W-1:0] DOSAGE_MAX = 16'd32768;
  localparam logic [Q_W-1:0]    Q16_ONE    = 17'd65536;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DOSE_MODE     = 2'd0;
  localparam reg_idx_t REG_MAF_THRESHOLD = 2'd1;
  localparam reg_idx_t REG_MAX_MISSING   = 2'd2;

  // command and result kind codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_READ     = 1'b1;
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  localparam logic [1:0] GENO_MISSING = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_KEPT     = 2'd0,
    VERDICT_MISSING  = 2'd1,
    VERDICT_FREQ     = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_t;

  // one buffered sample
  typedef struct packed {
    logic              missing;
    logic [DOSE_W-1:0] dosage;
  } entry_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic           done;
    logic           rem_nz;
    logic [Q_W-1:0] quot;
  } div_res_t;

endpackage

// ===== rtl/gdqi_div.sv =====
// shared restoring divider, one quotient bit per cycle, quotient bounded to 17 bits
module gdqi_div #(
  parameter int unsigned DW = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         hi,
  input  logic [gdqi_pkg::Q_W-1:0] lo,
  input  logic [DW-1:0]         divisor,
  output gdqi_pkg::div_res_t    res
);
  import gdqi_pkg::*;

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [Q_W-1:0]   lo_sh;
  logic [Q_W-1:0]   quot;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  // hi is below the divisor, so the partial remainder stays under DW bits
  assign trial = {rem, lo_sh[Q_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        rem   <= hi;
        lo_sh <= lo;
        dvs   <= divisor;
        quot  <= '0;
        cnt   <= '0;
      end else if (run) begin
        rem   <= fits ? diff[DW-1:0] : trial[DW-1:0];
        lo_sh <= {lo_sh[Q_W-2:0], 1'b0};
        quot  <= {quot[Q_W-2:0], fits};
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(Q_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done   = done;
  assign res.rem_nz = (rem != '0);
  assign res.quot   = quot;

endmodule

// ===== rtl/gdqi_buf.sv =====
// sample buffer, one write port and one registered read port
module gdqi_buf #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  gdqi_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output gdqi_pkg::entry_t rdata
);
  import gdqi_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/genotype_dosage_qc_impute.sv =====
// top level of the genotype dosage qc and mean impute block
//
// items arrive on a start/busy command port and are taken at an edge where
// start is high and busy is low. a load item (cmd 0) stores one sample of the
// current variant and leaves busy low, so samples can stream one per clock.
// the load marked last_sample closes the variant: busy then stays high while
// one shared 17-step restoring divider runs on the missing fraction and
// then, unless no sample was observed, on the allele frequency; the summary
// item shows on the result ports in the same cycle that busy falls. a read
// item (cmd 1) holds busy high for the registered buffer read and strobes
// its result as busy falls. every result is on the ports for exactly one cycle
// with done high; there is no back-pressure, so the receiver must take it then.
// configuration is written through cfg_we/cfg_index/cfg_data and must only
// change while busy is low and no result is pending. the buffer is not
// cleared at reset; reading a position never loaded returns undefined data.
module genotype_dosage_qc_impute #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic        sample_known,
  input  logic [1:0]  geno_code,
  input  logic        dosage_present_flag,
  input  logic [15:0] dosage_value,
  input  logic        last_sample,
  input  logic [11:0] read_index,
  // result side
  output logic        done,
  output logic        result_kind,
  output logic [1:0]  verdict,
  output logic [16:0] allele_freq,
  output logic [15:0] mean_dosage,
  output logic [12:0] obs_count,
  output logic [12:0] filled_count,
  output logic [15:0] dosage_out
);
  import gdqi_pkg::*;

  // count width holds MAX_SAMPLES itself; the sum holds MAX_SAMPLES full dosages
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SW = CW + 15;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_READ     = 7'b0000010,
    ST_MISS_GO  = 7'b0000100,
    ST_MISS_RUN = 7'b0001000,
    ST_FREQ_GO  = 7'b0010000,
    ST_FREQ_RUN = 7'b0100000,
    ST_SUM      = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic        use_stored;
  logic [15:0] maf_threshold;
  logic [16:0] miss_limit;

  // per-variant accumulators
  logic [CW-1:0] sample_total;
  logic [CW-1:0] observed_total;
  logic [SW-1:0] dose_total;
  logic [CW-1:0] call_fills;
  logic          overflow_flag;
  logic [15:0]   mean_register;

  // results of the two divisions
  logic           miss_fail;
  logic [Q_W-1:0] q2;
  logic           q2_nz;

  // read path
  logic   rd_ok;
  entry_t rd_entry;

  // sample selection
  entry_t new_entry;
  logic   new_observed;
  logic   new_filled;
  logic   buf_full;
  logic   accept;
  logic   buf_we;

  // shared divider operands
  logic [CW-1:0]  miss_count;
  logic           div_start;
  logic [CW-1:0]  div_hi;
  logic [Q_W-1:0] div_lo;
  logic [CW-1:0]  div_dvs;
  div_res_t       div_res;

  // summary evaluation
  logic [Q_W-1:0] freq_hi;
  logic           freq_fail;
  logic [Q_W-1:0] af_sat;
  logic [15:0]    mean_val;
  verdict_t       verdict_val;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      use_stored    <= 1'b1;
      maf_threshold <= '0;
      miss_limit    <= Q16_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DOSE_MODE:     use_stored    <= cfg_data[0];
        REG_MAF_THRESHOLD: maf_threshold <= cfg_data[15:0];
        REG_MAX_MISSING:   miss_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // choose stored dosage, hard call or missing for the incoming sample
  always_comb begin
    new_entry    = '{missing: 1'b1, dosage: '0};
    new_observed = 1'b0;
    new_filled   = 1'b0;
    if (!sample_known) begin
      new_entry.missing = 1'b1;
    end else if (use_stored && dosage_present_flag) begin
      new_entry.missing = 1'b0;
      new_entry.dosage  = (dosage_value > DOSAGE_MAX) ? DOSAGE_MAX : dosage_value;
      new_observed      = 1'b1;
    end else if (geno_code == GENO_MISSING) begin
      new_entry.missing = 1'b1;
    end else begin
      new_entry.missing = 1'b0;
      new_entry.dosage  = {geno_code, 14'd0};
      new_observed      = 1'b1;
      new_filled        = use_stored;
    end
  end

  assign buf_full = (sample_total >= CW'(MAX_SAMPLES));
  assign buf_we   = accept && (cmd == CMD_LOAD) && !buf_full;

  gdqi_buf #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (sample_total[AW-1:0]),
    .wdata (new_entry),
    .raddr (AW'(read_index)),
    .rdata (rd_entry)
  );

  // divider operands: missing test divides missing*65536 by the total,
  // frequency test divides 2*sum by the observed count
  assign miss_count = sample_total - observed_total;
  assign div_start  = (state == ST_MISS_GO) ||
                      ((state == ST_FREQ_GO) && (observed_total != '0));

  always_comb begin
    if (state == ST_MISS_GO) begin
      div_hi  = CW'(miss_count >> 1);
      div_lo  = {miss_count[0], 16'd0};
      div_dvs = sample_total;
    end else begin
      div_hi  = CW'(dose_total >> 16);
      div_lo  = {dose_total[15:0], 1'b0};
      div_dvs = observed_total;
    end
  end

  gdqi_div #(
    .DW (CW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .hi      (div_hi),
    .lo      (div_lo),
    .divisor (div_dvs),
    .res     (div_res)
  );

  // quotient and remainder flag give both exact fraction compares
  assign freq_hi   = Q16_ONE - {1'b0, maf_threshold};
  assign freq_fail = (q2 < {1'b0, maf_threshold}) || (q2 > freq_hi) ||
                     ((q2 == freq_hi) && q2_nz);
  assign af_sat    = (q2 > Q16_ONE) ? Q16_ONE : q2;
  // floor(floor(2s/n)/2) equals floor(s/n)
  assign mean_val  = af_sat[16:1];

  always_comb begin
    if (overflow_flag) begin
      verdict_val = VERDICT_OVERFLOW;
    end else if (miss_fail || (observed_total == '0)) begin
      verdict_val = VERDICT_MISSING;
    end else if (freq_fail) begin
      verdict_val = VERDICT_FREQ;
    end else begin
      verdict_val = VERDICT_KEPT;
    end
  end

  // sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_total   <= '0;
      observed_total <= '0;
      dose_total     <= '0;
      call_fills     <= '0;
      overflow_flag  <= 1'b0;
      mean_register  <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_READ) begin
              rd_ok <= ({20'd0, read_index} < 32'(MAX_SAMPLES));
              state <= ST_READ;
            end else begin
              if (buf_full) begin
                overflow_flag <= 1'b1;
              end else begin
                sample_total <= sample_total + 1'b1;
                if (new_observed) begin
                  observed_total <= observed_total + 1'b1;
                  dose_total     <= dose_total + SW'(new_entry.dosage);
                end
                if (new_filled) begin
                  call_fills <= call_fills + 1'b1;
                end
              end
              if (last_sample) begin
                state <= ST_MISS_GO;
              end
            end
          end
        end
        ST_READ: begin
          done        <= 1'b1;
          result_kind <= KIND_READ;
          verdict     <= VERDICT_KEPT;
          allele_freq <= '0;
          mean_dosage <= '0;
          obs_count    <= '0;
          filled_count <= '0;
          if (!rd_ok) begin
            dosage_out <= '0;
          end else if (rd_entry.missing) begin
            dosage_out <= mean_register;
          end else begin
            dosage_out <= rd_entry.dosage;
          end
          state <= ST_IDLE;
        end
        ST_MISS_GO: begin
          state <= ST_MISS_RUN;
        end
        ST_MISS_RUN: begin
          if (div_res.done) begin
            miss_fail <= (div_res.quot > miss_limit) ||
                         ((div_res.quot == miss_limit) && div_res.rem_nz);
            state     <= ST_FREQ_GO;
          end
        end
        ST_FREQ_GO: begin
          if (observed_total == '0) begin
            q2    <= '0;
            q2_nz <= 1'b0;
            state <= ST_SUM;
          end else begin
            state <= ST_FREQ_RUN;
          end
        end
        ST_FREQ_RUN: begin
          if (div_res.done) begin
            q2    <= div_res.quot;
            q2_nz <= div_res.rem_nz;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          done          <= 1'b1;
          result_kind   <= KIND_SUMMARY;
          verdict       <= verdict_val;
          allele_freq   <= af_sat;
          mean_dosage   <= mean_val;
          obs_count     <= CNT_OUT_W'(observed_total);
          filled_count  <= CNT_OUT_W'(call_fills);
          dosage_out    <= '0;
          mean_register <= mean_val;
          // next variant starts clean; buffer and mean stay
          sample_total   <= '0;
          observed_total <= '0;
          dose_total     <= '0;
          call_fills     <= '0;
          overflow_flag  <= 1'b0;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gdqi_checker.sv =====
// port-level checks of the genotype dosage qc block and its bind
module gdqi_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic        result_kind,
  input logic [1:0]  verdict,
  input logic [16:0] allele_freq,
  input logic [15:0] mean_dosage,
  input logic [12:0] obs_count,
  input logic [12:0] filled_count,
  input logic [15:0] dosage_out
);
  import gdqi_pkg::*;

  // every result comes out of a busy phase
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // read results carry only the dosage
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (result_kind == KIND_READ)) |->
      (verdict == VERDICT_KEPT) && (allele_freq == '0) && (mean_dosage == '0) &&
      (obs_count == '0) && (filled_count == '0))
    else $error("read result with summary fields set");

  // summary mean is half the frequency, both from one division
  a_summary_mean: assert property (@(posedge clk) disable iff (rst)
    (done && (result_kind == KIND_SUMMARY)) |->
      (mean_dosage == allele_freq[16:1]) && (dosage_out == '0))
    else $error("summary mean does not match frequency");

endmodule

bind genotype_dosage_qc_impute gdqi_checker u_gdqi_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .result_kind  (result_kind),
  .verdict      (verdict),
  .allele_freq  (allele_freq),
  .mean_dosage  (mean_dosage),
  .obs_count    (obs_count),
  .filled_count (filled_count),
  .dosage_out   (dosage_out)
);

// ===== bench/tb_top.sv =====
// self-checking testbench of the genotype dosage qc and mean impute block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gdqi_pkg::*;

  localparam int unsigned BUF_DEPTH     = 4096;
  localparam int unsigned ITEM_GOAL     = 1500;
  // a summary keeps busy high while the shared divider runs
  localparam int unsigned SETTLE_CYCLES = 45;
  // longest stretch with nothing taken: long gap plus summary plus settle time
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam logic [16:0] MISS_ENTRY    = 17'h10000;

  // one command item as the bench drives it
  typedef struct packed {
    logic        cmd;
    logic        known;
    logic [1:0]  geno;
    logic        present;
    logic [15:0] dose;
    logic        last;
    logic [11:0] index;
  } qc_item_t;

  localparam int unsigned ITEM_W = $bits(qc_item_t);

  // one result item as the block should show it
  typedef struct packed {
    logic        kind;
    verdict_t    verdict;
    logic [16:0] freq;
    logic [15:0] mean;
    logic [12:0] observed;
    logic [12:0] filled;
    logic [15:0] dose_out;
  } qc_result_t;

  // directed row: item plus a hand-written result where one is obvious
  typedef struct packed {
    qc_item_t   item;
    bit         typed;
    qc_result_t want;
  } qc_row_t;

  localparam qc_result_t NO_RESULT = '0;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DOSE_MODE;
  logic [16:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        cmd = CMD_LOAD;
  logic        sample_known = 1'b0;
  logic [1:0]  geno_code = '0;
  logic        dosage_present_flag = 1'b0;
  logic [15:0] dosage_value = '0;
  logic        last_sample = 1'b0;
  logic [11:0] read_index = '0;
  logic        busy;
  logic        done;
  logic        result_kind;
  logic [1:0]  verdict;
  logic [16:0] allele_freq;
  logic [15:0] mean_dosage;
  logic [12:0] obs_count;
  logic [12:0] filled_count;
  logic [15:0] dosage_out;

  genotype_dosage_qc_impute #(.MAX_SAMPLES(BUF_DEPTH)) dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .start               (start),
    .busy                (busy),
    .cmd                 (cmd),
    .sample_known        (sample_known),
    .geno_code           (geno_code),
    .dosage_present_flag (dosage_present_flag),
    .dosage_value        (dosage_value),
    .last_sample         (last_sample),
    .read_index          (read_index),
    .done                (done),
    .result_kind         (result_kind),
    .verdict             (verdict),
    .allele_freq         (allele_freq),
    .mean_dosage         (mean_dosage),
    .obs_count           (obs_count),
    .filled_count        (filled_count),
    .dosage_out          (dosage_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shadow copy of the block state and its configuration
  logic [16:0]     dose_buf [BUF_DEPTH];
  int unsigned     var_total = 0;
  int unsigned     var_observed = 0;
  longint unsigned var_sum = 0;
  int unsigned     var_filled = 0;
  bit              var_overflow = 1'b0;
  logic [15:0]     held_mean = '0;
  // buffer positions written so far; reads stay below this
  int unsigned     loaded_depth = 0;
  bit              cfg_prefer = 1'b1;
  int unsigned     cfg_maf = 0;
  int unsigned     cfg_max_missing = 65536;

  qc_result_t  expected_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit          no_idle = 1'b0;

  // hand-checked items first; the rest go through the dosage predictor
  qc_row_t directed_rows [15] = '{
    // lone hom alt hard call: frequency at one, filled from the call
    '{'{CMD_LOAD, 1'b1, 2'd2, 1'b0, 16'd0, 1'b1, 12'd0}, 1'b1,
      '{KIND_SUMMARY, VERDICT_KEPT, 17'd65536, 16'd32768, 13'd1, 13'd1, 16'd0}},
    // stored dosage at all ones saturates to two alleles
    '{'{CMD_LOAD, 1'b1, 2'd0, 1'b1, 16'hFFFF, 1'b1, 12'd0}, 1'b1,
      '{KIND_SUMMARY, VERDICT_KEPT, 17'd65536, 16'd32768, 13'd1, 13'd0, 16'd0}},
    // sample outside the file: nothing observed
    '{'{CMD_LOAD, 1'b0, 2'd1, 1'b1, 16'd16384, 1'b1, 12'd0}, 1'b1,
      '{KIND_SUMMARY, VERDICT_MISSING, 17'd0, 16'd0, 13'd0, 13'd0, 16'd0}},
    // missing entry read back as the zero mean just stored
    '{'{CMD_READ, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0, 12'd0}, 1'b1,
      '{KIND_READ, VERDICT_KEPT, 17'd0, 16'd0, 13'd0, 13'd0, 16'd0}},
    // four samples: hom ref call, missing call, dosage over missing call, top dosage
    '{'{CMD_LOAD, 1'b1, 2'd0, 1'b0, 16'd0, 1'b0, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_LOAD, 1'b1, GENO_MISSING, 1'b0, 16'd0, 1'b0, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_LOAD, 1'b1, GENO_MISSING, 1'b1, 16'd8000, 1'b0, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_LOAD, 1'b1, 2'd1, 1'b1, 16'd32768, 1'b1, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_READ, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0, 12'd1}, 1'b0, NO_RESULT},
    '{'{CMD_READ, 1'b1, 2'd3, 1'b1, 16'hFFFF, 1'b1, 12'd3}, 1'b1,
      '{KIND_READ, VERDICT_KEPT, 17'd0, 16'd0, 13'd0, 13'd0, 16'd32768}},
    // unknown sample beats a stored dosage
    '{'{CMD_LOAD, 1'b0, 2'd1, 1'b1, 16'd100, 1'b0, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_LOAD, 1'b1, 2'd2, 1'b0, 16'd0, 1'b1, 12'd0}, 1'b0, NO_RESULT},
    '{'{CMD_READ, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0, 12'd0}, 1'b0, NO_RESULT},
    // zero dosage alone: frequency zero, still kept with no threshold
    '{'{CMD_LOAD, 1'b1, 2'd2, 1'b1, 16'd0, 1'b1, 12'd0}, 1'b1,
      '{KIND_SUMMARY, VERDICT_KEPT, 17'd0, 16'd0, 13'd1, 13'd0, 16'd0}},
    '{'{CMD_READ, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0, 12'd1}, 1'b0, NO_RESULT}
  };

  // advance the shadow state by one item; returns 1 when a result is due
  function automatic bit qc_predict(input qc_item_t it, output qc_result_t r);
    logic [16:0]     entry;
    bit              seen;
    bit              from_call;
    longint unsigned n;
    longint unsigned obs;
    longint unsigned sum;
    longint unsigned freq;
    longint unsigned mean;
    r = '0;
    if (it.cmd == CMD_READ) begin
      entry = dose_buf[it.index];
      r.kind = KIND_READ;
      r.dose_out = entry[16] ? held_mean : entry[15:0];
      return 1'b1;
    end
    seen = 1'b0;
    from_call = 1'b0;
    // pick the dosage: stored when preferred, else the hard call, else missing
    if (!it.known) begin
      entry = MISS_ENTRY;
    end else if (cfg_prefer && it.present) begin
      entry = {1'b0, (it.dose > DOSAGE_MAX) ? DOSAGE_MAX : it.dose};
      seen = 1'b1;
    end else if (it.geno == GENO_MISSING) begin
      entry = MISS_ENTRY;
    end else begin
      entry = 17'(it.geno) << 14;
      seen = 1'b1;
      from_call = cfg_prefer;
    end
    // a full buffer drops the sample and marks the variant
    if (var_total >= BUF_DEPTH) begin
      var_overflow = 1'b1;
    end else begin
      dose_buf[var_total] = entry;
      var_total++;
      if (var_total > loaded_depth) loaded_depth = var_total;
      if (seen) begin
        var_observed++;
        var_sum += entry[15:0];
      end
      if (from_call) var_filled++;
    end
    if (!it.last) return 1'b0;

    n = var_total;
    obs = var_observed;
    sum = var_sum;
    freq = 0;
    mean = 0;
    if (obs != 0) begin
      freq = (2 * sum) / obs;
      mean = sum / obs;
    end
    if (freq > 65536) freq = 65536;
    if (mean > 32768) mean = 32768;
    r.kind = KIND_SUMMARY;
    // overflow first, then missing rate, then nothing observed, then frequency
    if (var_overflow) begin
      r.verdict = VERDICT_OVERFLOW;
    end else if ((n - obs) * 65536 > longint'(cfg_max_missing) * n) begin
      r.verdict = VERDICT_MISSING;
    end else if (obs == 0) begin
      r.verdict = VERDICT_MISSING;
    end else if (2 * sum < longint'(cfg_maf) * obs ||
                 2 * sum > longint'(65536 - cfg_maf) * obs) begin
      r.verdict = VERDICT_FREQ;
    end else begin
      r.verdict = VERDICT_KEPT;
    end
    r.freq = freq[16:0];
    r.mean = mean[15:0];
    r.observed = obs[12:0];
    r.filled = var_filled[12:0];
    // mean is held for later reads whatever the verdict
    held_mean = mean[15:0];
    var_total = 0;
    var_observed = 0;
    var_sum = 0;
    var_filled = 0;
    var_overflow = 1'b0;
    return 1'b1;
  endfunction

  // drive one item, wait for it to be taken, log its result, then maybe idle
  task automatic issue(input qc_item_t it, input bit typed = 1'b0,
                       input qc_result_t want = '0);
    qc_result_t  r;
    int unsigned roll;
    int unsigned gap;
    @(negedge clk);
    start <= 1'b1;
    cmd <= it.cmd;
    sample_known <= it.known;
    geno_code <= it.geno;
    dosage_present_flag <= it.present;
    dosage_value <= it.dose;
    last_sample <= it.last;
    read_index <= it.index;
    do @(posedge clk); while (busy !== 1'b0);
    if (qc_predict(it, r)) begin
      if (typed) r = want;
      expected_results = {expected_results, r};
    end
    items_sent++;
    // mostly back to back or short gaps, now and then a long one
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off until every result is in and the block has gone quiet
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers, block idle
  task automatic configure(input bit prefer, input int unsigned maf,
                           input int unsigned miss);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_DOSE_MODE;
    cfg_data <= 17'(prefer);
    @(negedge clk);
    cfg_index <= REG_MAF_THRESHOLD;
    cfg_data <= 17'(maf);
    @(negedge clk);
    cfg_index <= REG_MAX_MISSING;
    cfg_data <= 17'(miss);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_prefer = prefer;
    cfg_maf = maf;
    cfg_max_missing = miss;
  endtask

  // one whole variant of random samples with reads mixed in
  task automatic run_variant(input int unsigned sample_cnt, input int unsigned read_pct);
    qc_item_t    it;
    int unsigned miss_pct;
    int unsigned dose_pct;
    int unsigned bias;
    int unsigned i;
    // per-variant flavor: missing share, stored dosage share, allele skew
    case ($urandom_range(0, 4))
      0: miss_pct = 0;
      1: miss_pct = 5;
      2: miss_pct = 30;
      3: miss_pct = 80;
      default: miss_pct = 100;
    endcase
    case ($urandom_range(0, 2))
      0: dose_pct = 0;
      1: dose_pct = 50;
      default: dose_pct = 100;
    endcase
    bias = $urandom_range(0, 2);
    i = 0;
    while (i < sample_cnt) begin
      it = ITEM_W'({$urandom, $urandom});
      if (loaded_depth != 0 && $urandom_range(0, 99) < read_pct) begin
        // read with junk in the unused fields
        it.cmd = CMD_READ;
        it.index = 12'($urandom_range(0, loaded_depth - 1));
        issue(it);
      end else begin
        it.cmd = CMD_LOAD;
        it.known = 1'b1;
        it.present = ($urandom_range(0, 99) < dose_pct);
        case (bias)
          0: it.geno = 2'($urandom_range(0, 3));
          1: it.geno = ($urandom_range(0, 99) < 95) ? 2'd0 : 2'd1;
          default: it.geno = ($urandom_range(0, 99) < 95) ? 2'd2 : 2'd1;
        endcase
        case ($urandom_range(0, 3))
          0: it.dose = 16'($urandom_range(0, 65535));
          1: it.dose = 16'($urandom_range(0, 32768));
          default: begin
            if (bias == 1) it.dose = 16'($urandom_range(0, 600));
            else if (bias == 2) it.dose = DOSAGE_MAX - 16'($urandom_range(0, 600));
            else it.dose = 16'(it.geno) << 14;
          end
        endcase
        if ($urandom_range(0, 99) < miss_pct) begin
          if ($urandom_range(0, 1) != 0) begin
            it.known = 1'b0;
          end else begin
            it.geno = GENO_MISSING;
            it.present = 1'b0;
          end
        end
        it.last = (i == sample_cnt - 1);
        issue(it);
        i++;
      end
    end
  endtask

  // result checker: each strobe against the oldest expectation
  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    qc_result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: kind %0d", result_kind);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 17'(want.kind), 17'(result_kind));
        check_field("verdict", 17'(want.verdict), 17'(verdict));
        check_field("allele_freq", want.freq, allele_freq);
        check_field("mean_dosage", 17'(want.mean), 17'(mean_dosage));
        check_field("obs_count", 17'(want.observed), 17'(obs_count));
        check_field("filled_count", 17'(want.filled), 17'(filled_count));
        check_field("dosage_out", 17'(want.dose_out), 17'(dosage_out));
      end
    end
  end

  // watchdog: too long with neither an item nor a result taken
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("genotype_dosage_qc_impute: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned random_base;
    int unsigned roll;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed items under the reset configuration
    foreach (directed_rows[k]) begin
      issue(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end
    drain();

    // one sample past the buffer end: overflow verdict, whole buffer written
    configure(1'b1, 1, 65535);
    no_idle = 1'b1;
    run_variant(BUF_DEPTH + 1, 0);
    drain();

    // random phases, each with its own configuration
    random_base = items_sent;
    phase = 0;
    while (items_sent - random_base < ITEM_GOAL) begin
      case (phase % 5)
        0: configure(1'b1, 0, 65536);
        1: configure(1'b0, 32768, 0);
        2: configure(1'($urandom_range(0, 1)), $urandom_range(0, 32768),
                     $urandom_range(0, 65536));
        3: configure(1'b1, $urandom_range(0, 4000), $urandom_range(0, 30000));
        default: configure(1'($urandom_range(0, 1)), 32768 - $urandom_range(0, 3000),
                           $urandom_range(30000, 65536));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + 150;
      while (items_sent < phase_end) begin
        // now and then let every pending result come home first
        if ($urandom_range(0, 99) < 3) drain();
        roll = $urandom_range(0, 99);
        if (roll < 80) run_variant($urandom_range(1, 12), 15);
        else if (roll < 97) run_variant($urandom_range(13, 64), 15);
        else run_variant($urandom_range(65, 300), 15);
      end
      drain();
      phase++;
    end

    if (mismatches == 0) begin
      $display("genotype_dosage_qc_impute: match");
    end else begin
      $display("genotype_dosage_qc_impute: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gdqi_pkg.sv
rtl/gdqi_div.sv
rtl/gdqi_buf.sv
rtl/genotype_dosage_qc_impute.sv
rtl/gdqi_checker.sv
bench/tb_top.sv
